/* src/mwe_pkg.sv */
`timescale 1ns / 1ps

package mwe_pkg;

	localparam int ADDRESS_BITS = 9;
	localparam int HEADER_BITS  = ADDRESS_BITS + 3;
	localparam int DATA_BITS    = 8;
	localparam int COUNT_BITS   = 4;
	localparam int POLL_BITS    = 16;

	localparam logic [POLL_BITS-1:0] TIMEOUT_RESET = POLL_BITS'(200);

	// sequence phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_DATA   = 3'd2;
	localparam logic [2:0] PH_GAP    = 3'd3;
	localparam logic [2:0] PH_POLL   = 3'd4;

	// command codes
	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_WRITE     = 3'd1;
	localparam logic [2:0] CMD_ERASE     = 3'd2;
	localparam logic [2:0] CMD_ERASE_ALL = 3'd3;
	localparam logic [2:0] CMD_WRITE_ALL = 3'd4;
	localparam logic [2:0] CMD_ENABLE    = 3'd5;
	localparam logic [2:0] CMD_DISABLE   = 3'd6;

	// action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [DATA_BITS-1:0] DATA_ONES = '1;

	typedef struct packed {
		logic [2:0]              phase;
		logic [COUNT_BITS-1:0]   bit_count;
		logic                    clock_half;
		logic [HEADER_BITS-1:0]  shift_word;
		logic [2:0]              pend_cmd;
		logic [DATA_BITS-1:0]    pend_data;
		logic [POLL_BITS-1:0]    poll_count;
		logic [DATA_BITS-1:0]    captured;
		logic                    timeout_flag;
		logic                    cs;
		logic                    sck;
		logic                    sdo;
	} mwe_state_t;

	localparam mwe_state_t STATE_RESET = '{
		phase: PH_IDLE, bit_count: '0, clock_half: 1'b0, shift_word: '0,
		pend_cmd: '0, pend_data: '0, poll_count: '0, captured: '0,
		timeout_flag: 1'b0, cs: 1'b0, sck: 1'b0, sdo: 1'b0
	};

	// start bit, opcode and address as shifted out MSB first
	function automatic logic [HEADER_BITS-1:0] header_for(
		input logic [2:0] cmd,
		input logic [ADDRESS_BITS-1:0] addr
	);
		logic [HEADER_BITS-1:0] start;
		logic [HEADER_BITS-1:0] a;
		logic [HEADER_BITS-1:0] w;
		start = HEADER_BITS'(1) << (HEADER_BITS - 1);
		a = HEADER_BITS'(addr);
		case (cmd)
			CMD_READ:      w = start | (HEADER_BITS'(2) << (HEADER_BITS - 3)) | a;
			CMD_WRITE:     w = start | (HEADER_BITS'(1) << (HEADER_BITS - 3)) | a;
			CMD_ERASE:     w = start | (HEADER_BITS'(3) << (HEADER_BITS - 3)) | a;
			CMD_ERASE_ALL: w = start | (HEADER_BITS'(2) << (ADDRESS_BITS - 2));
			CMD_WRITE_ALL: w = start | (HEADER_BITS'(1) << (ADDRESS_BITS - 2));
			CMD_ENABLE:    w = start | (HEADER_BITS'(3) << (ADDRESS_BITS - 2));
			default:       w = start;
		endcase
		return w;
	endfunction

endpackage

/* src/mwe_step.sv */
`timescale 1ns / 1ps

// Next state of the sequencer for one word.
module mwe_step import mwe_pkg::*; (
	input  mwe_state_t                 cur,
	input  logic [POLL_BITS-1:0]       timeout_ticks,
	input  logic                       action,
	input  logic [2:0]                 command,
	input  logic [ADDRESS_BITS-1:0]    address,
	input  logic [DATA_BITS-1:0]       write_data,
	input  logic                       serial_in,
	output mwe_state_t                 nxt,
	output logic                       done
);

	logic                   hdr;
	logic                   last_bit;
	logic [HEADER_BITS-1:0] shifted;
	logic [COUNT_BITS-1:0]  count_inc;
	logic [POLL_BITS-1:0]   poll_inc;

	assign hdr       = (cur.phase == PH_HEADER);
	assign count_inc = cur.bit_count + COUNT_BITS'(1);
	assign last_bit  = hdr ? (count_inc == COUNT_BITS'(HEADER_BITS))
	                       : (count_inc == COUNT_BITS'(DATA_BITS));
	assign shifted   = hdr ? {cur.shift_word[HEADER_BITS-2:0], serial_in}
	                       : HEADER_BITS'({cur.shift_word[DATA_BITS-2:0], serial_in});
	assign poll_inc  = cur.poll_count + POLL_BITS'(1);

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (action == ACT_START) begin
			if (cur.phase == PH_IDLE && command <= CMD_DISABLE) begin
				nxt.pend_cmd   = command;
				nxt.pend_data  = write_data;
				nxt.shift_word = header_for(command, address);
				nxt.bit_count  = '0;
				nxt.clock_half = 1'b0;
				nxt.phase      = PH_HEADER;
				nxt.cs         = 1'b1;
				nxt.sck        = 1'b0;
				nxt.sdo        = 1'b0;
			end
		end else begin
			case (cur.phase)
				PH_HEADER, PH_DATA: begin
					if (!cur.clock_half) begin
						nxt.sdo        = hdr ? cur.shift_word[HEADER_BITS-1]
						                     : cur.shift_word[DATA_BITS-1];
						nxt.sck        = 1'b1;
						nxt.clock_half = 1'b1;
					end else begin
						nxt.sck        = 1'b0;
						nxt.clock_half = 1'b0;
						nxt.shift_word = shifted;
						nxt.bit_count  = count_inc;
						if (last_bit) begin
							nxt.bit_count = '0;
							nxt.sdo       = 1'b0;
							if (hdr) begin
								if (cur.pend_cmd == CMD_READ) begin
									nxt.shift_word = HEADER_BITS'(DATA_ONES);
									nxt.phase      = PH_DATA;
								end else if (cur.pend_cmd == CMD_WRITE ||
								             cur.pend_cmd == CMD_WRITE_ALL) begin
									nxt.shift_word = HEADER_BITS'(cur.pend_data);
									nxt.phase      = PH_DATA;
								end else begin
									nxt.phase = PH_GAP;
								end
							end else if (cur.pend_cmd == CMD_READ) begin
								nxt.captured = shifted[DATA_BITS-1:0];
								nxt.phase    = PH_IDLE;
								nxt.cs       = 1'b0;
								done         = 1'b1;
							end else begin
								nxt.phase = PH_GAP;
							end
						end
					end
				end
				PH_GAP: begin
					nxt.cs         = 1'b0;
					nxt.sck        = 1'b0;
					nxt.sdo        = 1'b0;
					nxt.poll_count = '0;
					nxt.phase      = PH_POLL;
				end
				PH_POLL: begin
					nxt.cs = 1'b1;
					if (serial_in) begin
						nxt.timeout_flag = 1'b0;
						done             = 1'b1;
					end else begin
						nxt.poll_count = poll_inc;
						if (poll_inc == timeout_ticks) begin
							nxt.timeout_flag = 1'b1;
							done             = 1'b1;
						end
					end
					if (done) begin
						nxt.phase      = PH_IDLE;
						nxt.bit_count  = '0;
						nxt.clock_half = 1'b0;
						nxt.cs         = 1'b0;
						nxt.sck        = 1'b0;
						nxt.sdo        = 1'b0;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

/* src/microwire_eeprom_command_master.sv */
`timescale 1ns / 1ps

// Microwire command master for a 512x8 serial EEPROM. Each input word is
// either a start (action 0: read, write, erase, erase all, write all, write
// enable or write disable; ignored while a sequence runs) or one half-bit
// tick (action 1). The block returns exactly one result word per input word,
// carrying the pin levels to drive (chip_select, serial_clock, serial_out)
// plus busy, done, the last byte read and the ready-poll timeout flag. A
// sequence sends 12 header bits MSB first (start bit, opcode, 9-bit address),
// then 8 data bits in or out as the command needs; every bit takes two ticks
// (drive and raise clock, then sample serial_in and lower clock). Non-read
// commands then spend one tick with select low and poll serial_in, one tick
// per poll, until it reads one or cfg_write_data's timeout count is reached.
// One word per clock is taken whenever the output register is empty or being
// drained in the same cycle: the next sequencer state is computed
// combinationally and the result sits in the output register. A word's
// result appears on the result side in the cycle after it is accepted.
module microwire_eeprom_command_master import mwe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration: ready poll timeout in ticks
	input  logic                    cfg_write_en,
	input  logic [POLL_BITS-1:0]    cfg_write_data,
	// input words
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic [2:0]              command,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic [DATA_BITS-1:0]    write_data,
	input  logic                    serial_in,
	// result words
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    chip_select,
	output logic                    serial_clock,
	output logic                    serial_out,
	output logic                    busy_res,
	output logic                    done_res,
	output logic [DATA_BITS-1:0]    read_byte,
	output logic                    timed_out
);

	mwe_state_t           state_q;
	mwe_state_t           state_nxt;
	logic                 done_nxt;
	logic [POLL_BITS-1:0] timeout_q;
	logic                 out_valid_q;
	logic                 accept;

	// Take a word when the result register is free or empties this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_write_en) begin
			timeout_q <= cfg_write_data;
		end
	end

	mwe_step u_step (
		.cur           (state_q),
		.timeout_ticks (timeout_q),
		.action        (action),
		.command       (command),
		.address       (address),
		.write_data    (write_data),
		.serial_in     (serial_in),
		.nxt           (state_nxt),
		.done          (done_nxt)
	);

	// Advance the sequencer only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result fields until the next accepted word replaces them.
	always_ff @(posedge clk) begin
		if (accept) begin
			chip_select  <= state_nxt.cs;
			serial_clock <= state_nxt.sck;
			serial_out   <= state_nxt.sdo;
			busy_res     <= (state_nxt.phase != PH_IDLE);
			done_res     <= done_nxt;
			read_byte    <= state_nxt.captured;
			timed_out    <= state_nxt.timeout_flag;
		end
	end

	assign out_valid = out_valid_q;

endmodule
